### hw/rtl/gar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gar_pkg
// Types and constants shared by the glyph alpha run blender and its channels.
// ----------------------------------------------------------------------------
package gar_pkg;

  // longest run before a forced flush
  localparam int unsigned MaxRowWidth = 255;

  localparam logic [7:0] AlphaBack = 8'h00;
  localparam logic [7:0] AlphaFore = 8'hFF;

  // configuration register indexes
  localparam logic CfgFgColor = 1'b0;
  localparam logic CfgBgColor = 1'b1;

  // command queue depth
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] alpha;
    logic       row_end;
  } pix_t;

  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  run_length;
    logic        last;
  } cmd_t;

  // blend one RGB565 pixel between foreground and background
  function automatic logic [15:0] blend565(logic [7:0] a, logic [15:0] fgc, logic [15:0] bgc);
    logic [7:0]  na;
    logic [13:0] r_sum;
    logic [14:0] g_sum;
    logic [13:0] b_sum;
    na    = AlphaFore - a;
    r_sum = 14'({fgc[15:11], 1'b1}) * 14'(a) + 14'({bgc[15:11], 1'b1}) * 14'(na);
    g_sum = 15'({fgc[10:5], 1'b1}) * 15'(a) + 15'({bgc[10:5], 1'b1}) * 15'(na);
    b_sum = 14'({fgc[4:0], 1'b1}) * 14'(a) + 14'({bgc[4:0], 1'b1}) * 14'(na);
    return {r_sum[13:9], g_sum[14:9], b_sum[13:9]};
  endfunction

endpackage

### hw/rtl/gar_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gar_pix_if / gar_cmd_if
// Valid/ready channels for glyph pixels in and write commands out.
// ----------------------------------------------------------------------------
interface gar_pix_if;
  logic          valid;
  logic          ready;
  gar_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gar_cmd_if;
  logic          valid;
  logic          ready;
  gar_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/glyph_alpha_run_blender_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_alpha_run_blender_unit
// Turns glyph coverage pixels into RGB565 (colour, run length) write commands.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock while the queue has room. A pixel is held in
// the input register, then its zero, one or two commands are written into a
// four-entry command queue, which drains one command per clock to the write
// port while the sink is ready. The input side keeps taking a pixel every
// cycle as long as the queue has room for two more commands after this
// cycle's drain. A pixel adds two commands when it flushes a pending run and
// then emits its own command: a partial pixel after a run, or a run pixel that
// closes its own run (row end or maximum width) after a run of the other kind.
// Every flushed run covers at least one earlier pixel, so commands never outpace
// pixels and sustained throughput is one pixel per clock unless the sink stalls.
// A command is offered once its pixel has moved from the input register to the queue.
module glyph_alpha_run_blender_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  gar_pix_if.sink     pix_i,
  gar_cmd_if.source   cmd_o
);

  logic [15:0] fg_color_q, bg_color_q;
  logic        in_valid_q;
  gar_pkg::pix_t in_q;
  logic [7:0]  fore_run_q, fore_run_d;
  logic [7:0]  back_run_q, back_run_d;

  gar_pkg::cmd_t queue_q [gar_pkg::QueueDepth];
  logic [gar_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [gar_pkg::QueueCntW-1:0] count_q;

  logic advance, pop;
  logic c0_valid, c1_valid;
  gar_pkg::cmd_t c0, c1;
  logic [7:0] fore_inc, back_inc;
  logic [1:0] n_push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q <= '0;
      bg_color_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gar_pkg::CfgFgColor: fg_color_q <= cfg_wdata_i;
        gar_pkg::CfgBgColor: bg_color_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // queue handshake and stage advance
  assign pop     = cmd_o.valid && cmd_o.ready;
  assign advance = in_valid_q &&
                   ((count_q - gar_pkg::QueueCntW'(pop)) <= gar_pkg::QueueCntW'(2));
  assign pix_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      in_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.ready && pix_i.valid) begin
      in_q <= pix_i.data;
    end
  end

  // run counting and command generation
  assign fore_inc = fore_run_q + 8'd1;
  assign back_inc = back_run_q + 8'd1;

  always_comb begin
    fore_run_d = fore_run_q;
    back_run_d = back_run_q;
    c0_valid   = 1'b0;
    c1_valid   = 1'b0;
    c0         = '0;
    c1         = '0;
    if (in_q.alpha == gar_pkg::AlphaBack) begin
      c0_valid   = fore_run_q != 8'd0;
      c0         = '{color: fg_color_q, run_length: fore_run_q, last: 1'b0};
      fore_run_d = '0;
      back_run_d = back_inc;
      if (in_q.row_end || 32'(back_inc) >= gar_pkg::MaxRowWidth) begin
        c1_valid   = 1'b1;
        c1         = '{color: bg_color_q, run_length: back_inc, last: 1'b0};
        back_run_d = '0;
      end
    end else if (in_q.alpha == gar_pkg::AlphaFore) begin
      c0_valid   = back_run_q != 8'd0;
      c0         = '{color: bg_color_q, run_length: back_run_q, last: 1'b0};
      back_run_d = '0;
      fore_run_d = fore_inc;
      if (in_q.row_end || 32'(fore_inc) >= gar_pkg::MaxRowWidth) begin
        c1_valid   = 1'b1;
        c1         = '{color: fg_color_q, run_length: fore_inc, last: 1'b0};
        fore_run_d = '0;
      end
    end else begin
      // at most one run is pending; background takes priority
      if (back_run_q != 8'd0) begin
        c0_valid = 1'b1;
        c0       = '{color: bg_color_q, run_length: back_run_q, last: 1'b0};
      end else if (fore_run_q != 8'd0) begin
        c0_valid = 1'b1;
        c0       = '{color: fg_color_q, run_length: fore_run_q, last: 1'b0};
      end
      c1_valid   = 1'b1;
      c1         = '{color: gar_pkg::blend565(in_q.alpha, fg_color_q, bg_color_q),
                     run_length: 8'd1, last: 1'b0};
      fore_run_d = '0;
      back_run_d = '0;
    end
    // mark the final command of this transaction
    if (c1_valid) begin
      c1.last = 1'b1;
    end else begin
      c0.last = 1'b1;
    end
  end

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_run_q <= '0;
      back_run_q <= '0;
    end else if (advance) begin
      fore_run_q <= fore_run_d;
      back_run_q <= back_run_d;
    end
  end

  // command queue
  assign n_push = advance ? {1'b0, c0_valid} + {1'b0, c1_valid} : 2'd0;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (c0_valid) begin
        queue_q[wr_ptr_q] <= c0;
        if (c1_valid) begin
          queue_q[wr_ptr_q + gar_pkg::QueuePtrW'(1)] <= c1;
        end
      end else if (c1_valid) begin
        queue_q[wr_ptr_q] <= c1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + gar_pkg::QueuePtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + gar_pkg::QueuePtrW'(pop);
      count_q  <= count_q + gar_pkg::QueueCntW'(n_push) - gar_pkg::QueueCntW'(pop);
    end
  end

  // output side
  assign cmd_o.valid = count_q != '0;
  assign cmd_o.data  = queue_q[rd_ptr_q];

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the glyph alpha run blender against a cycle-free predictor of its
// run counting and RGB565 blending. Pixels go in through a queue-fed driver,
// write commands come out through a monitor with random back-pressure, and
// every command is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned RandomPixels = 450;

  typedef struct {
    gar_pkg::pix_t pix;
    int unsigned   gap;
  } pending_pix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = gar_pkg::CfgFgColor;
  logic [15:0] cfg_wdata_i = '0;

  gar_pix_if pix ();
  gar_cmd_if cmd ();

  glyph_alpha_run_blender_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix.sink),
    .cmd_o       (cmd.source)
  );

  // pixels waiting to be driven, commands waiting to be seen
  pending_pix_t  pixel_q[$];
  gar_pkg::cmd_t expected_cmd_q[$];

  // predictor copy of colors and pending runs
  logic [15:0] fg_color_q = '0;
  logic [15:0] bg_color_q = '0;
  int unsigned fg_run_len = 0;
  int unsigned bg_run_len = 0;

  // idle behavior of each side, changed per phase
  bit          src_calm = 1'b0;
  bit          snk_calm = 1'b0;
  int unsigned src_wait = 0;
  int unsigned snk_wait = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // one channel: widened with a rounding bit, weighted, shifted right by 9
  function automatic int unsigned mix_channel(int unsigned f, int unsigned b,
                                              logic [7:0] a);
    int unsigned wa;
    int unsigned wb;
    wa = a;
    wb = 255 - wa;
    return (((f << 1) | 1) * wa + ((b << 1) | 1) * wb) >> 9;
  endfunction

  function automatic logic [15:0] blend_rgb565(logic [7:0] a);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = 5'(mix_channel(fg_color_q[15:11], bg_color_q[15:11], a));
    g = 6'(mix_channel(fg_color_q[10:5], bg_color_q[10:5], a));
    b = 5'(mix_channel(fg_color_q[4:0], bg_color_q[4:0], a));
    return {r, g, b};
  endfunction

  function automatic void push_command(logic [15:0] color, int unsigned len);
    gar_pkg::cmd_t c;
    c.color      = color;
    c.run_length = 8'(len);
    c.last       = 1'b0;
    expected_cmd_q.push_back(c);
  endfunction

  // commands caused by one accepted pixel
  function automatic void predict_commands(gar_pkg::pix_t p);
    int unsigned first;
    first = expected_cmd_q.size();
    if (p.alpha == gar_pkg::AlphaBack) begin
      if (fg_run_len != 0) begin
        push_command(fg_color_q, fg_run_len);
        fg_run_len = 0;
      end
      bg_run_len++;
      if (p.row_end || bg_run_len >= gar_pkg::MaxRowWidth) begin
        push_command(bg_color_q, bg_run_len);
        bg_run_len = 0;
      end
    end else if (p.alpha == gar_pkg::AlphaFore) begin
      if (bg_run_len != 0) begin
        push_command(bg_color_q, bg_run_len);
        bg_run_len = 0;
      end
      fg_run_len++;
      if (p.row_end || fg_run_len >= gar_pkg::MaxRowWidth) begin
        push_command(fg_color_q, fg_run_len);
        fg_run_len = 0;
      end
    end else begin
      if (bg_run_len != 0) begin
        push_command(bg_color_q, bg_run_len);
        bg_run_len = 0;
      end
      if (fg_run_len != 0) begin
        push_command(fg_color_q, fg_run_len);
        fg_run_len = 0;
      end
      push_command(blend_rgb565(p.alpha), 1);
    end
    if (expected_cmd_q.size() > first) begin
      expected_cmd_q[expected_cmd_q.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.data  <= '0;
      src_wait  <= 0;
    end else if (!pix.valid || pix.ready) begin
      if (pixel_q.size() == 0) begin
        pix.valid <= 1'b0;
      end else if (src_wait < pixel_q[0].gap) begin
        pix.valid <= 1'b0;
        src_wait  <= src_wait + 1;
      end else begin
        pix.valid <= 1'b1;
        pix.data  <= pixel_q[0].pix;
        src_wait  <= 0;
        void'(pixel_q.pop_front());
      end
    end
  end

  // prediction on each accepted pixel transaction
  always @(posedge clk_i) begin
    if (rst_ni && pix.valid && pix.ready) begin
      predict_commands(pix.data);
    end
  end

  // command monitor with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    gar_pkg::cmd_t want;
    int unsigned n;
    if (!rst_ni) begin
      cmd.ready <= 1'b0;
      snk_wait  <= 0;
    end else if (cmd.valid && cmd.ready) begin
      if (expected_cmd_q.size() == 0) begin
        report_mismatch("unexpected command color", cmd.data.color, 0);
      end else begin
        want = expected_cmd_q.pop_front();
        if (cmd.data.color != want.color)
          report_mismatch("color", cmd.data.color, want.color);
        if (cmd.data.run_length != want.run_length)
          report_mismatch("run_length", cmd.data.run_length, want.run_length);
        if (cmd.data.last != want.last)
          report_mismatch("last", cmd.data.last, want.last);
      end
      n = draw_gap(snk_calm);
      if (n == 0) begin
        cmd.ready <= 1'b1;
      end else begin
        cmd.ready <= 1'b0;
        snk_wait  <= n;
      end
    end else if (!cmd.ready) begin
      if (snk_wait <= 1) cmd.ready <= 1'b1;
      if (snk_wait != 0) snk_wait <= snk_wait - 1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_pixel(logic [7:0] alpha, logic row_end);
    pending_pix_t item;
    item.pix.alpha   = alpha;
    item.pix.row_end = row_end;
    item.gap         = draw_gap(src_calm);
    pixel_q.push_back(item);
  endtask

  // wait until every pixel is in and every command is out, then a little more
  task automatic settle();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || pix.valid || expected_cmd_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gar_pkg::CfgFgColor) fg_color_q = value;
    else bg_color_q = value;
  endtask

  task automatic start_phase(logic [15:0] fg, logic [15:0] bg);
    settle();
    write_reg(gar_pkg::CfgFgColor, fg);
    write_reg(gar_pkg::CfgBgColor, bg);
    src_calm = ($urandom_range(0, 3) == 0);
    snk_calm = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned total;
    int unsigned long_runs;
    int unsigned width;
    int unsigned seg_left;
    int unsigned kind;
    logic [7:0]  alpha;
    logic        row_end;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single-pixel rows, run changes, flush before blend, row ends
    start_phase(16'hFFFF, 16'h0000);
    queue_pixel(gar_pkg::AlphaBack, 1'b1);
    queue_pixel(gar_pkg::AlphaFore, 1'b1);
    queue_pixel(gar_pkg::AlphaBack, 1'b0);
    queue_pixel(gar_pkg::AlphaBack, 1'b0);
    queue_pixel(gar_pkg::AlphaFore, 1'b0);
    queue_pixel(gar_pkg::AlphaFore, 1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'd254, 1'b0);
    queue_pixel(gar_pkg::AlphaBack, 1'b0);
    queue_pixel(gar_pkg::AlphaBack, 1'b0);
    queue_pixel(gar_pkg::AlphaFore, 1'b1);
    queue_pixel(gar_pkg::AlphaFore, 1'b0);
    queue_pixel(gar_pkg::AlphaFore, 1'b0);
    queue_pixel(gar_pkg::AlphaBack, 1'b1);
    queue_pixel(8'd127, 1'b1);
    queue_pixel(gar_pkg::AlphaBack, 1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(gar_pkg::AlphaFore, 1'b0);

    // directed: inverted colors, run left pending across a color change
    start_phase(16'h0000, 16'hFFFF);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'd85, 1'b1);
    queue_pixel(8'd170, 1'b0);
    queue_pixel(8'd254, 1'b1);
    queue_pixel(gar_pkg::AlphaBack, 1'b1);

    // random rows, mostly well formed, with a few overlong runs
    total     = 0;
    long_runs = 0;
    while (total < RandomPixels) begin
      start_phase(pick_color(), pick_color());
      repeat ($urandom_range(3, 7)) begin
        if (long_runs < 3 && $urandom_range(0, 9) == 0) begin
          // run near or past the forced flush width with no row end
          alpha = $urandom_range(0, 1) ? gar_pkg::AlphaFore : gar_pkg::AlphaBack;
          width = $urandom_range(250, 300);
          repeat (width) queue_pixel(alpha, 1'b0);
          long_runs++;
          total += width;
        end
        width    = $urandom_range(1, 40);
        seg_left = 0;
        kind     = 0;
        for (int unsigned i = 0; i < width; i++) begin
          if (seg_left == 0) begin
            kind     = $urandom_range(0, 9);
            seg_left = $urandom_range(1, 12);
          end
          if (kind < 4) alpha = gar_pkg::AlphaBack;
          else if (kind < 7) alpha = gar_pkg::AlphaFore;
          else alpha = 8'($urandom_range(1, 254));
          if (i == width - 1) row_end = ($urandom_range(0, 9) != 0);
          else row_end = ($urandom_range(0, 29) == 0);
          queue_pixel(alpha, row_end);
          seg_left--;
          total++;
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
